### hw/rtl/tdpt_pkg.sv
// Shared constants for the trial-division prime tester.
// No dependencies; imported by tdpt_rem and trial_division_prime_test_top.
package tdpt_pkg;

    localparam int CAND_WIDTH        = 32;   // width of the candidate port
    localparam int VALUE_WIDTH_DEF   = 32;   // default datapath width
    localparam int VALUE_WIDTH_MIN   = 2;
    localparam int VALUE_WIDTH_MAX   = 64;

    // 6k +/- 1 wheel
    localparam int WHEEL_START = 5;
    localparam int WHEEL_STEP  = 6;
    localparam int WHEEL_GAP   = 2;
    localparam int SMALL_PRIME_A = 2;
    localparam int SMALL_PRIME_B = 3;

    // (i+6)^2 - i^2 = 12*i + 36; the increment itself grows by 72 per step
    localparam int SQ_INIT    = WHEEL_START * WHEEL_START;
    localparam int DELTA_INIT = 2 * WHEEL_STEP * WHEEL_START + WHEEL_STEP * WHEEL_STEP;
    localparam int DELTA_STEP = 2 * WHEEL_STEP * WHEEL_STEP;

    // extra bits so the running square and its increment never wrap
    localparam int SQ_GUARD = 5;

endpackage

### hw/rtl/tdpt_rem.sv
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Depends on tdpt_pkg.
module tdpt_rem import tdpt_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [VALUE_WIDTH-1:0] divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] remainder
);

    localparam int W  = VALUE_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quot_reg, quot_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    assign trial = {rem_reg, quot_reg[W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(W);
            quot_next = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[W-2:0], 1'b0};
            // partial remainder always stays below a nonzero divisor
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[W-1:0];
            end else begin
                rem_next = trial[W-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

### hw/rtl/trial_division_prime_test_top.sv
// Trial-division primality tester, 6k +/- 1 wheel, one shared remainder unit.
// n < 2, n = 2 or 3, and even n are decided straight from the input; otherwise
// n mod 3 is checked first, then each wheel step takes two remainders in the
// shared unit (n mod i and n mod (i+2)), up to ~11000 steps at 32 bits.
// Throughput: one word at a time; s_ready is high only in the idle state.
// Reset (aresetn, synchronous, active low) returns to idle with no word out.
module trial_division_prime_test_top import tdpt_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input word channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CAND_WIDTH-1:0] s_candidate,
    // result word channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_is_prime
);

    localparam int W  = VALUE_WIDTH;
    localparam int IW = W + 1;              // wheel divisor, room for i + 6
    localparam int SW = W + SQ_GUARD;       // running square and its increment

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MOD3  = 3'd1;  // waiting on n mod 3
    localparam logic [2:0] ST_BOUND = 3'd2;  // i*i <= n ?
    localparam logic [2:0] ST_DIVA  = 3'd3;  // waiting on n mod i
    localparam logic [2:0] ST_DIVB  = 3'd4;  // waiting on n mod (i+2)
    localparam logic [2:0] ST_DONE  = 3'd5;  // verdict ready for the output reg

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  n_reg, n_next;          // candidate under test
    logic [IW-1:0] i_reg, i_next;          // wheel divisor
    logic [SW-1:0] sq_reg, sq_next;        // i*i, kept incrementally
    logic [SW-1:0] d_reg, d_next;          // (i+6)^2 - i^2
    logic          res_reg, res_next;      // verdict
    logic          start_reg, start_next;  // kick to the remainder unit
    logic [W-1:0]  dsr_reg, dsr_next;      // divisor handed to the unit
    logic          m_valid_reg, m_valid_next;
    logic          m_prime_reg, m_prime_next;

    logic [W-1:0]  cand_n;
    logic          rem_done;
    logic [W-1:0]  rem_val;
    logic          rem_zero;
    logic [IW-1:0] i_gap;

    // only the low VALUE_WIDTH bits of the candidate count
    generate
        if (W <= CAND_WIDTH) begin : g_trunc
            assign cand_n = s_candidate[W-1:0];
        end else begin : g_ext
            assign cand_n = {{(W - CAND_WIDTH){1'b0}}, s_candidate};
        end
    endgenerate

    assign rem_zero = (rem_val == '0);
    assign i_gap    = i_reg + IW'(WHEEL_GAP);
    assign s_ready  = (state_reg == ST_IDLE);

    tdpt_rem #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (n_reg),
        .divisor   (dsr_reg),
        .done      (rem_done),
        .remainder (rem_val)
    );

    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        d_next       = d_reg;
        res_next     = res_reg;
        start_next   = 1'b0;
        dsr_next     = dsr_reg;
        m_valid_next = m_valid_reg;
        m_prime_next = m_prime_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    n_next = cand_n;
                    if (cand_n < W'(SMALL_PRIME_A)) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else if (cand_n == W'(SMALL_PRIME_A) ||
                                 cand_n == W'(SMALL_PRIME_B)) begin
                        res_next   = 1'b1;
                        state_next = ST_DONE;
                    end else if (!cand_n[0]) begin
                        // even and above 2
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        start_next = 1'b1;
                        dsr_next   = W'(SMALL_PRIME_B);
                        state_next = ST_MOD3;
                    end
                end
            end
            ST_MOD3: begin
                if (rem_done) begin
                    if (rem_zero) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        i_next     = IW'(WHEEL_START);
                        sq_next    = SW'(SQ_INIT);
                        d_next     = SW'(DELTA_INIT);
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_BOUND: begin
                if (sq_reg > SW'(n_reg)) begin
                    // no divisor up to sqrt(n)
                    res_next   = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    start_next = 1'b1;
                    dsr_next   = i_reg[W-1:0];
                    state_next = ST_DIVA;
                end
            end
            ST_DIVA: begin
                if (rem_done) begin
                    if (rem_zero) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        start_next = 1'b1;
                        dsr_next   = i_gap[W-1:0];
                        state_next = ST_DIVB;
                    end
                end
            end
            ST_DIVB: begin
                if (rem_done) begin
                    if (rem_zero) begin
                        res_next   = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        i_next     = i_reg + IW'(WHEEL_STEP);
                        sq_next    = sq_reg + d_reg;
                        d_next     = d_reg + SW'(DELTA_STEP);
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_DONE: begin
                // hand off once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_prime_next = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        n_reg       <= n_next;
        i_reg       <= i_next;
        sq_reg      <= sq_next;
        d_reg       <= d_next;
        res_reg     <= res_next;
        dsr_reg     <= dsr_next;
        m_prime_reg <= m_prime_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_prime_reg;

endmodule
